@@ rtl/core/first_fit_chunk_allocator_unit_macros.svh @@
// Assertion macros shared by the chunk allocator RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef FIRST_FIT_CHUNK_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_CHUNK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define FFCA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define FFCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ffca_pkg.sv @@
// Types, constants and command/status structs of the chunk allocator.
// No dependencies; used by ffca_ifs, ffca_dpath, ffca_ctrl, the top level and the bench.
package ffca_pkg;

  localparam int unsigned POOL_BYTES_DEF  = 65536;
  localparam int unsigned MAX_CHUNKS_DEF  = 64;
  localparam int unsigned GUARD_BYTES_DEF = 8;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned STATUS_W = 3;

  typedef logic [ADDR_W-1:0] chunk_addr_t;
  typedef logic [SIZE_W-1:0] chunk_size_t;

  typedef struct packed {
    logic        busy;
    chunk_size_t size;
    chunk_addr_t start;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_DOUBLE   = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    WR_MOVE,
    WR_REST,
    WR_GRANT,
    WR_MERGE
  } wr_sel_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    logic       wr_en;
    wr_sel_t    wr_sel;
    logic       cap_prev;
    logic       cap_cur;
    logic       cap_next;
    logic       cap_merge;
    logic       use_prev;
    logic       use_next;
    logic       cnt_inc;
    logic [1:0] cnt_dec;
    logic       res_load;
    status_t    res_status;
  } ffca_cmd_t;

  typedef struct packed {
    logic kind;
    logic req_zero;
    logic hit;
    logic cur_busy;
    logic prev_free;
    logic next_free;
    logic rest_zero;
  } ffca_sts_t;

endpackage

@@ rtl/core/ffca_ifs.sv @@
// Valid/ready channel interfaces for requests and results of the allocator.
// Depends on ffca_pkg for the field widths.
interface ffca_in_if;
  import ffca_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [SIZE_W-1:0] req_size;
  logic [ADDR_W-1:0] free_addr;

  modport source (output valid, kind, req_size, free_addr, input ready);
  modport sink (input valid, kind, req_size, free_addr, output ready);
endinterface

interface ffca_out_if;
  import ffca_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   grant_addr;
  logic [STATUS_W-1:0] status;

  modport source (output valid, grant_addr, status, input ready);
  modport sink (input valid, grant_addr, status, output ready);
endinterface

@@ rtl/core/ffca_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/ffca_dpath.sv @@
// Datapath of the allocator: chunk table RAM, entry registers, size arithmetic,
// chunk count and result register. Depends on ffca_pkg and ffca_ram.
`include "first_fit_chunk_allocator_unit_macros.svh"

module ffca_dpath #(
  parameter int unsigned POOL_BYTES  = ffca_pkg::POOL_BYTES_DEF,
  parameter int unsigned MAX_CHUNKS  = ffca_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned GUARD_BYTES = ffca_pkg::GUARD_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 kind,
  input  logic [ffca_pkg::SIZE_W-1:0]          req_size,
  input  logic [ffca_pkg::ADDR_W-1:0]          free_addr,
  input  ffca_pkg::ffca_cmd_t                  cmd,
  input  logic [$clog2(MAX_CHUNKS)-1:0]        rd_addr,
  input  logic [$clog2(MAX_CHUNKS)-1:0]        wr_addr,
  output ffca_pkg::ffca_sts_t                  sts,
  output logic [$clog2(MAX_CHUNKS+1)-1:0]      count,
  output logic [ffca_pkg::ADDR_W-1:0]          grant_addr,
  output logic [ffca_pkg::STATUS_W-1:0]        status
);
  import ffca_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam logic [CNT_W-1:0]  MAX_CNT   = CNT_W'(MAX_CHUNKS);
  localparam logic [SIZE_W:0]   GUARD_X   = (SIZE_W + 1)'(GUARD_BYTES);
  localparam chunk_size_t       INIT_SIZE = SIZE_W'(POOL_BYTES - GUARD_BYTES);
  localparam entry_t INIT_ENT = '{busy: 1'b0, size: INIT_SIZE, start: '0};

  logic              kind_r;
  chunk_size_t       req_r;
  chunk_addr_t       addr_r;
  entry_t            prev_r, cur_r, next_r, mrg_r;
  logic [CNT_W-1:0]  count_r;
  logic              e0_init_r;
  logic              rd0_r;
  chunk_addr_t       grant_r;
  status_t           status_r;

  logic [ENTRY_W-1:0] ram_q;
  entry_t             rd_ent;
  entry_t             wr_ent;
  logic [SIZE_W:0]    need;
  logic [SIZE_W:0]    rest;
  logic               rest_zero;
  logic [SIZE_W:0]    merge_base;
  logic [SIZE_W:0]    merge_sum;

  ffca_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_CHUNKS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_ent),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  // Entry 0 holds the whole pool after reset until its first write.
  assign rd_ent    = rd0_r ? INIT_ENT : entry_t'(ram_q);
  assign need      = {1'b0, req_r} + GUARD_X;
  assign rest      = {1'b0, cur_r.size} - need;
  assign rest_zero = ({1'b0, cur_r.size} == need);

  always_comb begin
    merge_base = cmd.use_prev ? ({1'b0, prev_r.size} + GUARD_X + {1'b0, cur_r.size})
                              : {1'b0, cur_r.size};
    merge_sum  = cmd.use_next ? (merge_base + GUARD_X + {1'b0, next_r.size}) : merge_base;
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_MOVE:  wr_ent = rd_ent;
      WR_REST:  wr_ent = '{busy: 1'b0, size: rest[SIZE_W-1:0],
                           start: cur_r.start + need[ADDR_W-1:0]};
      WR_GRANT: wr_ent = '{busy: 1'b1, size: (rest_zero ? cur_r.size : req_r),
                           start: cur_r.start};
      WR_MERGE: wr_ent = mrg_r;
      default:  wr_ent = rd_ent;
    endcase
  end

  always_comb begin
    sts.kind      = kind_r;
    sts.req_zero  = (req_r == '0);
    sts.hit       = kind_r ? (rd_ent.start == addr_r)
                           : (!rd_ent.busy && ({1'b0, rd_ent.size} >= need));
    sts.cur_busy  = cur_r.busy;
    sts.prev_free = !prev_r.busy;
    sts.next_free = !next_r.busy;
    sts.rest_zero = rest_zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= CNT_W'(1);
      e0_init_r <= 1'b1;
      rd0_r     <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count_r <= count_r + 1'b1;
      end else begin
        count_r <= count_r - CNT_W'(cmd.cnt_dec);
      end
      if (cmd.wr_en && (wr_addr == '0)) begin
        e0_init_r <= 1'b0;
      end
      rd0_r <= cmd.rd_en && (rd_addr == '0) && e0_init_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind;
      req_r  <= req_size;
      addr_r <= free_addr;
    end
    if (cmd.cap_prev) begin
      prev_r <= rd_ent;
    end
    if (cmd.cap_cur) begin
      cur_r <= rd_ent;
    end
    if (cmd.cap_next) begin
      next_r <= rd_ent;
    end
    if (cmd.cap_merge) begin
      mrg_r <= '{busy: 1'b0, size: merge_sum[SIZE_W-1:0],
                 start: (cmd.use_prev ? prev_r.start : cur_r.start)};
    end
    if (cmd.res_load) begin
      status_r <= cmd.res_status;
      grant_r  <= (!kind_r && (cmd.res_status == ST_OK)) ? cur_r.start : '0;
    end
  end

  assign count      = count_r;
  assign grant_addr = grant_r;
  assign status     = status_r;

  `FFCA_ASSERT_IMPL(a_count_range, 1'b1, (count_r != '0) && (count_r <= MAX_CNT), "chunk count out of range")
  `FFCA_ASSERT_IMPL(a_split_room, cmd.cnt_inc, count_r < MAX_CNT, "split with a full chunk table")
  `FFCA_ASSERT_NEXT(a_init_clear, cmd.wr_en && (wr_addr == '0), !e0_init_r, "entry 0 still reads as reset value")

endmodule

@@ rtl/core/ffca_ctrl.sv @@
// Controller of the allocator: request sequencing, table scan and shift
// addressing, and the result handshake. Depends on ffca_pkg.
`include "first_fit_chunk_allocator_unit_macros.svh"

module ffca_ctrl #(
  parameter int unsigned MAX_CHUNKS = ffca_pkg::MAX_CHUNKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  input  ffca_pkg::ffca_sts_t              sts,
  input  logic [$clog2(MAX_CHUNKS+1)-1:0]  count,
  output ffca_pkg::ffca_cmd_t              cmd,
  output logic [$clog2(MAX_CHUNKS)-1:0]    rd_addr,
  output logic [$clog2(MAX_CHUNKS)-1:0]    wr_addr
);
  import ffca_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHUNKS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_A_DEC,
    S_F_NEXT,
    S_F_DEC,
    S_SHIFT,
    S_W_REST,
    S_W_GRANT,
    S_W_MERGE,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic [IDX_W-1:0]  hit_r, hit_nxt;
  logic [IDX_W-1:0]  mv_src_r, mv_src_nxt;
  logic [IDX_W-1:0]  mv_last_r, mv_last_nxt;
  logic              mv_up_r, mv_up_nxt;
  logic              mv_issue_r, mv_issue_nxt;
  logic [1:0]        dist_r, dist_nxt;
  logic [IDX_W-1:0]  base_r, base_nxt;
  status_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  last_idx;
  logic [CNT_W-1:0]  hp1_c;
  logic [IDX_W-1:0]  hp1;
  logic              use_prev;
  logic              use_next;
  logic [CNT_W-1:0]  src_c;

  always_comb begin
    cnt_m1   = count - CNT_W'(1);
    last_idx = cnt_m1[IDX_W-1:0];
    hp1_c    = CNT_W'(hit_r) + CNT_W'(1);
    hp1      = hp1_c[IDX_W-1:0];
    use_prev = (hit_r != '0) && sts.prev_free;
    use_next = (hp1_c < count) && sts.next_free;
    // First entry that survives the merge and must move down.
    src_c    = hp1_c + CNT_W'(use_next);
  end

  always_comb begin
    state_nxt     = state_r;
    rd_idx_nxt    = rd_idx_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    hit_nxt       = hit_r;
    mv_src_nxt    = mv_src_r;
    mv_last_nxt   = mv_last_r;
    mv_up_nxt     = mv_up_r;
    mv_issue_nxt  = mv_issue_r;
    dist_nxt      = dist_r;
    base_nxt      = base_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    rd_addr       = rd_idx_r[IDX_W-1:0];
    wr_addr       = '0;
    in_ready      = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          rd_idx_nxt = '0;
          state_nxt  = S_SCAN;
        end
      end

      S_SCAN: begin
        // Reads run one entry ahead of the compare on the returned data.
        if (rd_idx_r < count) begin
          cmd.rd_en   = 1'b1;
          rd_idx_nxt  = rd_idx_r + 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = rd_idx_r[IDX_W-1:0];
        end
        if (!sts.kind && sts.req_zero) begin
          res_nxt   = ST_ZERO;
          state_nxt = S_RESP;
        end else if (chk_vld_r) begin
          if (sts.hit) begin
            cmd.cap_cur = 1'b1;
            hit_nxt     = chk_idx_r;
            state_nxt   = sts.kind ? S_F_NEXT : S_A_DEC;
          end else begin
            cmd.cap_prev = 1'b1;
            if (chk_idx_r == last_idx) begin
              res_nxt   = sts.kind ? ST_NOTFOUND : ST_NOSPACE;
              state_nxt = S_RESP;
            end
          end
        end
      end

      S_A_DEC: begin
        if (sts.rest_zero) begin
          state_nxt = S_W_GRANT;
        end else if (count == MAX_CNT) begin
          res_nxt   = ST_FULL;
          state_nxt = S_RESP;
        end else if (hp1_c < count) begin
          mv_src_nxt   = last_idx;
          mv_last_nxt  = hp1;
          mv_up_nxt    = 1'b1;
          mv_issue_nxt = 1'b1;
          state_nxt    = S_SHIFT;
        end else begin
          state_nxt = S_W_REST;
        end
      end

      S_F_NEXT: begin
        // The entry after the hit was read during the hit cycle.
        cmd.cap_next = 1'b1;
        state_nxt    = S_F_DEC;
      end

      S_F_DEC: begin
        if (!sts.cur_busy) begin
          res_nxt   = ST_DOUBLE;
          state_nxt = S_RESP;
        end else begin
          cmd.cap_merge = 1'b1;
          cmd.use_prev  = use_prev;
          cmd.use_next  = use_next;
          dist_nxt      = {1'b0, use_prev} + {1'b0, use_next};
          base_nxt      = use_prev ? (hit_r - 1'b1) : hit_r;
          if ((use_prev || use_next) && (src_c < count)) begin
            mv_src_nxt   = src_c[IDX_W-1:0];
            mv_last_nxt  = last_idx;
            mv_up_nxt    = 1'b0;
            mv_issue_nxt = 1'b1;
            state_nxt    = S_SHIFT;
          end else begin
            state_nxt = S_W_MERGE;
          end
        end
      end

      S_SHIFT: begin
        if (mv_issue_r) begin
          cmd.rd_en   = 1'b1;
          rd_addr     = mv_src_r;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = mv_src_r;
          if (mv_src_r == mv_last_r) begin
            mv_issue_nxt = 1'b0;
          end else begin
            mv_src_nxt = mv_up_r ? (mv_src_r - 1'b1) : (mv_src_r + 1'b1);
          end
        end
        if (chk_vld_r) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = WR_MOVE;
          wr_addr    = mv_up_r ? (chk_idx_r + 1'b1) : (chk_idx_r - IDX_W'(dist_r));
          if (!mv_issue_r) begin
            state_nxt = mv_up_r ? S_W_REST : S_W_MERGE;
          end
        end
      end

      S_W_REST: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_REST;
        wr_addr     = hp1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = S_W_GRANT;
      end

      S_W_GRANT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_GRANT;
        wr_addr    = hit_r;
        res_nxt    = ST_OK;
        state_nxt  = S_RESP;
      end

      S_W_MERGE: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = WR_MERGE;
        wr_addr     = base_r;
        cmd.cnt_dec = dist_r;
        res_nxt     = ST_OK;
        state_nxt   = S_RESP;
      end

      S_RESP: begin
        cmd.res_status = res_r;
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_idx_r    <= '0;
      chk_vld_r   <= 1'b0;
      chk_idx_r   <= '0;
      hit_r       <= '0;
      mv_src_r    <= '0;
      mv_last_r   <= '0;
      mv_up_r     <= 1'b0;
      mv_issue_r  <= 1'b0;
      dist_r      <= '0;
      base_r      <= '0;
      res_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_idx_r    <= rd_idx_nxt;
      chk_vld_r   <= chk_vld_nxt;
      chk_idx_r   <= chk_idx_nxt;
      hit_r       <= hit_nxt;
      mv_src_r    <= mv_src_nxt;
      mv_last_r   <= mv_last_nxt;
      mv_up_r     <= mv_up_nxt;
      mv_issue_r  <= mv_issue_nxt;
      dist_r      <= dist_nxt;
      base_r      <= base_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `FFCA_ASSERT_IMPL(a_rw_apart, cmd.rd_en && cmd.wr_en, rd_addr != wr_addr, "table read and write collide")
  `FFCA_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second request taken while one is in work")
  `FFCA_ASSERT_IMPL(a_scan_range, (state_r == S_SCAN) && chk_vld_r, CNT_W'(chk_idx_r) < count, "scan beyond the chunk count")

endmodule

@@ rtl/core/first_fit_chunk_allocator_unit.sv @@
// Top level of the first-fit chunk allocator with coalescing.
// Depends on ffca_pkg, ffca_ifs, ffca_ctrl and ffca_dpath.
//
//   port     dir   payload                          beat taken when
//   in_ch    sink  kind, req_size, free_addr        valid && ready
//   out_ch   src   grant_addr, status               valid && ready
//
// One request at a time. A request takes the beat in the idle state, scans the
// table up to the matching chunk (or the last index on a miss), shifts the
// entries behind a split or merge, then writes back and loads the result.
// The single read port of the chunk table RAM serialises the scan and shift.
// A new request is taken while a result beat still waits on out_ch; the next
// result is held until that beat goes. Reset is synchronous and needs no sweep.
module first_fit_chunk_allocator_unit #(
  parameter int unsigned POOL_BYTES  = ffca_pkg::POOL_BYTES_DEF,
  parameter int unsigned MAX_CHUNKS  = ffca_pkg::MAX_CHUNKS_DEF,
  parameter int unsigned GUARD_BYTES = ffca_pkg::GUARD_BYTES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  ffca_in_if.sink     in_ch,
  ffca_out_if.source  out_ch
);
  import ffca_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W = $clog2(MAX_CHUNKS + 1);

  ffca_cmd_t         cmd;
  ffca_sts_t         sts;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [CNT_W-1:0]  count;

  ffca_ctrl #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .sts      (sts),
    .count    (count),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr)
  );

  ffca_dpath #(
    .POOL_BYTES (POOL_BYTES),
    .MAX_CHUNKS (MAX_CHUNKS),
    .GUARD_BYTES(GUARD_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .kind      (in_ch.kind),
    .req_size  (in_ch.req_size),
    .free_addr (in_ch.free_addr),
    .cmd       (cmd),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .sts       (sts),
    .count     (count),
    .grant_addr(out_ch.grant_addr),
    .status    (out_ch.status)
  );

endmodule

@@ sim/first_fit_chunk_allocator_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for first_fit_chunk_allocator_unit: a directed table, then random
// allocate/free traffic, each result compared with a chunk-table model kept here.
// Depends on ffca_pkg, the channel interfaces in ffca_ifs and the allocator RTL.
module first_fit_chunk_allocator_unit_test;
  import ffca_pkg::*;

  localparam int unsigned POOL        = POOL_BYTES_DEF;
  localparam int unsigned MAXC        = MAX_CHUNKS_DEF;
  localparam int unsigned GUARD       = GUARD_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned TAIL_CYCLES = 2 * MAXC + 16;
  localparam int unsigned PHASE_ITEMS = 230;
  localparam int unsigned PLAN_ROWS   = 24;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct {
    chunk_addr_t grant;
    status_t     status;
  } result_t;

  // Rows with typed set carry a result read straight off the allocator rules.
  typedef struct {
    logic        kind;
    chunk_size_t req;
    chunk_addr_t addr;
    bit          typed;
    chunk_addr_t grant;
    status_t     status;
  } plan_row_t;

  logic clk;
  logic rst_n;

  ffca_in_if  in_ch ();
  ffca_out_if out_ch ();

  first_fit_chunk_allocator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Chunk table as the bench sees it, in address order.
  chunk_addr_t chunk_base  [MAXC];
  chunk_size_t chunk_len   [MAXC];
  bit          chunk_taken [MAXC];
  int unsigned chunk_total;

  result_t     awaited_results[$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  int unsigned error_count;

  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{KIND_ALLOC, 17'd0,      16'd0,     1'b1, 16'd0,   ST_ZERO},
    '{KIND_ALLOC, 17'd131071, 16'd0,     1'b1, 16'd0,   ST_NOSPACE},
    '{KIND_ALLOC, 17'd65536,  16'd0,     1'b1, 16'd0,   ST_NOSPACE},
    '{KIND_ALLOC, 17'd65521,  16'd0,     1'b1, 16'd0,   ST_NOSPACE},
    '{KIND_ALLOC, 17'd65520,  16'd0,     1'b1, 16'd0,   ST_OK},
    '{KIND_ALLOC, 17'd1,      16'd0,     1'b1, 16'd0,   ST_NOSPACE},
    '{KIND_FREE,  17'd0,      16'd0,     1'b1, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd0,      16'd0,     1'b1, 16'd0,   ST_DOUBLE},
    '{KIND_FREE,  17'd0,      16'd65535, 1'b1, 16'd0,   ST_NOTFOUND},
    '{KIND_ALLOC, 17'd100,    16'd0,     1'b1, 16'd0,   ST_OK},
    '{KIND_ALLOC, 17'd200,    16'd0,     1'b1, 16'd108, ST_OK},
    '{KIND_ALLOC, 17'd300,    16'd0,     1'b0, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd0,      16'd108,   1'b0, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd0,      16'd0,     1'b0, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd0,      16'd316,   1'b0, 16'd0,   ST_OK},
    '{KIND_ALLOC, 17'd10,     16'd0,     1'b0, 16'd0,   ST_OK},
    '{KIND_ALLOC, 17'd10,     16'd0,     1'b0, 16'd0,   ST_OK},
    '{KIND_ALLOC, 17'd10,     16'd0,     1'b0, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd0,      16'd0,     1'b0, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd0,      16'd18,    1'b0, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd0,      16'd36,    1'b0, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd131071, 16'd4,     1'b1, 16'd0,   ST_NOTFOUND},
    '{KIND_ALLOC, 17'd1,      16'd65535, 1'b1, 16'd0,   ST_OK},
    '{KIND_FREE,  17'd0,      16'd0,     1'b1, 16'd0,   ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_table();
    int j;
    for (j = 0; j < MAXC; j++) begin
      chunk_base[j]  = '0;
      chunk_len[j]   = '0;
      chunk_taken[j] = 1'b0;
    end
    chunk_len[0] = chunk_size_t'(POOL - GUARD);
    chunk_total  = 1;
  endfunction

  function automatic void drop_chunk(input int unsigned idx);
    int unsigned j;
    for (j = idx; j + 1 < chunk_total; j++) begin
      chunk_base[j]  = chunk_base[j+1];
      chunk_len[j]   = chunk_len[j+1];
      chunk_taken[j] = chunk_taken[j+1];
    end
    chunk_total--;
  endfunction

  // Applies one request to the table and returns the result the block must give.
  function automatic void apply_request(input logic kind, input chunk_size_t req,
                                        input chunk_addr_t addr,
                                        output chunk_addr_t grant, output status_t status);
    int          idx;
    int unsigned j;
    int unsigned need;
    int unsigned rest;
    grant = '0;
    idx   = -1;
    if (kind == KIND_ALLOC) begin
      need = int'(req) + GUARD;
      if (req == '0) begin
        status = ST_ZERO;
      end else begin
        for (j = 0; j < chunk_total; j++) begin
          if (idx < 0 && !chunk_taken[j] && int'(chunk_len[j]) >= need) idx = j;
        end
        if (idx < 0) begin
          status = ST_NOSPACE;
        end else begin
          rest = int'(chunk_len[idx]) - need;
          if (rest != 0 && chunk_total >= MAXC) begin
            status = ST_FULL;
          end else begin
            // Split off the free remainder right behind the granted part.
            if (rest != 0) begin
              for (j = chunk_total; j > idx + 1; j--) begin
                chunk_base[j]  = chunk_base[j-1];
                chunk_len[j]   = chunk_len[j-1];
                chunk_taken[j] = chunk_taken[j-1];
              end
              chunk_total++;
              chunk_base[idx+1]  = chunk_addr_t'(int'(chunk_base[idx]) + need);
              chunk_len[idx+1]   = chunk_size_t'(rest);
              chunk_taken[idx+1] = 1'b0;
              chunk_len[idx]     = req;
            end
            chunk_taken[idx] = 1'b1;
            grant  = chunk_base[idx];
            status = ST_OK;
          end
        end
      end
    end else begin
      for (j = 0; j < chunk_total; j++) begin
        if (idx < 0 && chunk_base[j] == addr) idx = j;
      end
      if (idx < 0) begin
        status = ST_NOTFOUND;
      end else if (!chunk_taken[idx]) begin
        status = ST_DOUBLE;
      end else begin
        chunk_taken[idx] = 1'b0;
        if (idx + 1 < chunk_total && !chunk_taken[idx+1]) begin
          chunk_len[idx] = chunk_size_t'(int'(chunk_len[idx]) + GUARD + chunk_len[idx+1]);
          drop_chunk(idx + 1);
        end
        if (idx > 0 && !chunk_taken[idx-1]) begin
          chunk_len[idx-1] = chunk_size_t'(int'(chunk_len[idx-1]) + GUARD + chunk_len[idx]);
          drop_chunk(idx);
        end
        status = ST_OK;
      end
    end
  endfunction

  // Index of a random chunk that is busy or free as asked, or -1 if none is.
  function automatic int pick_chunk(input bit want_taken);
    int unsigned j;
    int unsigned hits;
    int unsigned k;
    hits = 0;
    for (j = 0; j < chunk_total; j++) begin
      if (chunk_taken[j] == want_taken) hits++;
    end
    if (hits == 0) return -1;
    k = $urandom_range(hits - 1, 0);
    for (j = 0; j < chunk_total; j++) begin
      if (chunk_taken[j] == want_taken) begin
        if (k == 0) return j;
        k--;
      end
    end
    return -1;
  endfunction

  task automatic send_request(input logic kind, input chunk_size_t req,
                              input chunk_addr_t addr, input bit typed,
                              input chunk_addr_t typed_grant, input status_t typed_status);
    int unsigned gap;
    result_t     predicted;
    gap = 0;
    while ($urandom_range(99, 0) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.req_size  <= req;
    in_ch.free_addr <= addr;
    do @(posedge clk); while (!in_ch.ready);
    apply_request(kind, req, addr, predicted.grant, predicted.status);
    if (typed) begin
      predicted.grant  = typed_grant;
      predicted.status = typed_status;
    end
    awaited_results.push_back(predicted);
  endtask

  // Mostly small allocations and frees of live chunks, so the table fills up and
  // drains again; the rest are larger allocations, exact fits, double frees, stray
  // addresses and oversized requests.
  task automatic send_random();
    int          pick;
    int          idx;
    logic        kind;
    chunk_size_t req;
    chunk_addr_t addr;
    pick = $urandom_range(99, 0);
    kind = KIND_ALLOC;
    req  = chunk_size_t'($urandom_range(64, 1));
    addr = chunk_addr_t'($urandom);
    if (pick < 8) begin
      req = chunk_size_t'($urandom_range(4096, 1));
    end else if (pick < 12) begin
      req = chunk_size_t'($urandom_range(16384, 1));
    end else if (pick < 45) begin
      // Small allocation as drawn above.
    end else if (pick < 80) begin
      idx = pick_chunk(1'b1);
      if (idx >= 0) begin
        kind = KIND_FREE;
        addr = chunk_base[idx];
      end
    end else if (pick < 85) begin
      idx = pick_chunk(1'b0);
      if (idx >= 0 && chunk_len[idx] > GUARD) req = chunk_size_t'(chunk_len[idx] - GUARD);
    end else if (pick < 90) begin
      idx = pick_chunk(1'b0);
      if (idx >= 0) begin
        kind = KIND_FREE;
        addr = chunk_base[idx];
      end
    end else if (pick < 95) begin
      kind = KIND_FREE;
      req  = chunk_size_t'($urandom_range(131071, 0));
    end else begin
      req = chunk_size_t'($urandom_range(131071, 0));
    end
    send_request(kind, req, addr, 1'b0, '0, ST_OK);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    result_t oldest;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result beat with nothing pending: grant_addr %0d status %0d",
                 $time, out_ch.grant_addr, out_ch.status);
        error_count++;
      end else begin
        oldest = awaited_results.pop_front();
        if (out_ch.grant_addr !== oldest.grant) begin
          $display("%0t: grant_addr expected %0d actual %0d",
                   $time, oldest.grant, out_ch.grant_addr);
          error_count++;
        end
        if (out_ch.status !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, oldest.status, out_ch.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned row;
    int unsigned phase;
    send_idle_pct   = 6;
    recv_idle_pct   = 68;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= KIND_ALLOC;
    in_ch.req_size  <= '0;
    in_ch.free_addr <= '0;
    clear_table();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < PLAN_ROWS; row++) begin
      send_request(directed_plan[row].kind, directed_plan[row].req,
                   directed_plan[row].addr, directed_plan[row].typed,
                   directed_plan[row].grant, directed_plan[row].status);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 6;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 6;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end
    in_ch.valid <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
